/* sv/pats_pkg.sv */
// Package for the priority aging task scheduler: types, constants, codes.
// No dependencies.
`timescale 1ns / 1ps
package pats_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int ACC_WIDTH = 16;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};
  localparam logic [7:0] TIMESLOT_RESET = 8'd5;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SWITCH = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic        slot_valid;
    logic        slot_blocked;
    logic [3:0]  slot_priority;
    logic [15:0] slot_sleep;
    logic        current_killed;
  } in_word_t;

  typedef struct packed {
    logic [7:0] timeslot_left;
    logic       switch_due;
    logic [3:0] chosen_slot;
    logic       chose_idle;
  } out_word_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           state;
    logic [3:0]           priority_v;
    logic [ACC_WIDTH-1:0] acc;
    logic [15:0]          sleep;
  } entry_t;
endpackage

/* sv/priority_aging_task_scheduler.sv */
// Priority aging task scheduler top level: slot table memory and sweep sequencer.
// Depends on pats_pkg.
`timescale 1ns / 1ps
// Usage:
//   Pulse start with an input word while busy is low. action selects tick,
//   switch or write slot. Every accepted word gives one result word, shown
//   for one cycle with done high; the receiver cannot stall it. busy drops
//   in the done cycle, so the next word can go in at the edge taking the result.
//   Write: a single memory write in S_WR; the result follows from S_DONE.
//   Tick: the slot table is swept one entry a cycle through the
//   registered-read memory (read, modify, write back); S_DONE then
//   gives the result.
//   Switch: the same sweep, then a read bubble and the winner's write-back.
//   The sweep over the memory sets the rate.
//   Action 3 gives an all-zero result on the next cycle.
//   timeslot_length is written by cfg_we/cfg_data; it takes effect at the
//   next counter reload.
//   Reset: a clearing pass writes zero to every slot with busy high;
//   then the block is idle.
module priority_aging_task_scheduler
  import pats_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      done,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data
);
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_WIN   = 6'b001000,
    S_DONE  = 6'b010000,
    S_WR    = 6'b100000
  } state_t;

  state_t state;
  entry_t mem [NUM_SLOTS];
  entry_t rd_data;
  logic [SLOT_W:0] rd_idx;      // issue index, may reach NUM_SLOTS
  logic [SLOT_W:0] wb_idx;      // index of rd_data
  logic            rd_live;
  logic            mem_we;
  logic [SLOT_W-1:0] mem_wa;
  entry_t          mem_wd;
  in_word_t        cmd;
  logic [7:0]      timeslot_length, slice_counter;
  logic [SLOT_W-1:0] running_slot, best;
  logic            running_is_idle, first_switch, found, save_ok;
  logic [ACC_WIDTH-1:0] max_acc;
  logic [4:0]      max_pri;     // bit 4 marks "none yet" (-1)
  out_word_t       res;

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_idx[SLOT_W-1:0]];
  end

  // per-entry modify during sweep
  entry_t e, e_mod;
  logic [ACC_WIDTH:0] acc_sum;
  logic better, is_ready;
  logic [1:0] st_eff;
  always_comb begin
    e = rd_data;
    e_mod = e;
    st_eff = e.state;
    if (cmd.action == ACT_SWITCH && save_ok && e.valid && e.state == ST_RUNNING &&
        wb_idx[SLOT_W-1:0] == running_slot)
      st_eff = ST_READY;
    e_mod.state = st_eff;
    is_ready = e.valid && st_eff == ST_READY;
    acc_sum = {1'b0, e.acc} + {{(ACC_WIDTH-4){1'b0}}, 1'b0, e.priority_v} + 1'b1;
    better = is_ready && (e.acc > max_acc ||
             (e.acc == max_acc && ($signed({1'b0, e.priority_v}) >= $signed(max_pri))));
    if (cmd.action == ACT_TICK) begin
      if (e.valid && e.sleep != 16'd0) begin
        e_mod.sleep = e.sleep - 16'd1;
        if (e.sleep == 16'd1) e_mod.state = ST_READY;
      end
    end else if (is_ready) begin
      e_mod.acc = acc_sum[ACC_WIDTH] ? ACC_MAX : acc_sum[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wb_idx[SLOT_W-1:0];
    mem_wd = e_mod;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = rd_idx[SLOT_W-1:0];
        mem_wd = '0;
      end
      S_SWEEP: mem_we = rd_live;
      S_WIN: begin
        // winner entry is valid in rd_data only after the read bubble
        mem_we = found && rd_live;
        mem_wa = best;
        mem_wd = rd_data;
        mem_wd.acc = '0;
        mem_wd.state = ST_RUNNING;
      end
      S_WR: begin
        mem_we = 1'b1;
        mem_wa = cmd.slot;
        mem_wd.valid = cmd.slot_valid;
        mem_wd.state = cmd.slot_blocked ? ST_BLOCKED : ST_READY;
        mem_wd.priority_v = cmd.slot_priority;
        mem_wd.acc = '0;
        mem_wd.sleep = cmd.slot_sleep;
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      rd_idx <= '0;
      rd_live <= 1'b0;
      done <= 1'b0;
      timeslot_length <= TIMESLOT_RESET;
      slice_counter <= TIMESLOT_RESET;
      running_slot <= '0;
      running_is_idle <= 1'b1;
      first_switch <= 1'b1;
      found <= 1'b0;
    end else begin
      done <= (state == S_DONE) || (state == S_IDLE && start && in_word.action == ACT_NOP);
      if (cfg_we) timeslot_length <= cfg_data;
      case (state)
        S_CLEAR: begin
          if (rd_idx == (SLOT_W+1)'(NUM_SLOTS - 1)) begin
            state <= S_IDLE;
            rd_idx <= '0;
          end else rd_idx <= rd_idx + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            cmd <= in_word;
            res <= '0;
            case (in_word.action)
              ACT_TICK, ACT_SWITCH: begin
                state <= S_SWEEP;
                rd_idx <= (SLOT_W+1)'(1);
                rd_live <= 1'b1;
                wb_idx <= '0;
                found <= 1'b0;
                max_acc <= '0;
                max_pri <= 5'h1f;
                save_ok <= !first_switch && !in_word.current_killed && !running_is_idle;
              end
              ACT_WRITE: begin
                state <= S_WR;
                rd_idx <= '0;
                rd_live <= 1'b0;
              end
              default: begin
                out_word <= '0;
                rd_idx <= '0;
                rd_live <= 1'b0;
              end
            endcase
          end else begin
            rd_idx <= '0;
            rd_live <= 1'b0;
          end
        end
        S_SWEEP: begin
          if (better) begin
            found <= 1'b1;
            best <= wb_idx[SLOT_W-1:0];
            max_acc <= e.acc;
            max_pri <= {1'b0, e.priority_v};
          end
          wb_idx <= rd_idx;
          if (wb_idx == (SLOT_W+1)'(NUM_SLOTS - 1)) begin
            rd_live <= 1'b0;
            if (cmd.action == ACT_TICK) begin
              rd_idx <= '0;
              state <= S_DONE;
              if (slice_counter == 8'd1) begin
                slice_counter <= timeslot_length;
                res <= '{timeslot_left: 8'd0, switch_due: 1'b1, chosen_slot: 4'd0,
                         chose_idle: 1'b0};
              end else begin
                slice_counter <= slice_counter - 8'd1;
                res <= '{timeslot_left: slice_counter - 8'd1, switch_due: 1'b0,
                         chosen_slot: 4'd0, chose_idle: 1'b0};
              end
            end else begin
              rd_idx <= {1'b0, better ? wb_idx[SLOT_W-1:0] : best};
              state <= S_WIN;
            end
          end else rd_idx <= rd_idx + 1'b1;
        end
        S_WIN: begin
          // bubble: the read at best goes out after the sweep's last write-back
          if (!rd_live) begin
            rd_live <= 1'b1;
          end else begin
            rd_live <= 1'b0;
            rd_idx <= '0;
            slice_counter <= timeslot_length;
            first_switch <= 1'b0;
            running_slot <= found ? best : '0;
            running_is_idle <= !found;
            res <= '{timeslot_left: 8'd0, switch_due: 1'b0,
                     chosen_slot: (found ? best : 4'd0), chose_idle: !found};
            state <= S_DONE;
          end
        end
        S_WR: state <= S_DONE;
        S_DONE: begin
          out_word <= res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_WIN waits through a bubble so rd_data holds the winner's written-back entry
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy || done)
    else $error("accepted word neither started nor completed");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst)
    done && $past(cmd.action) == ACT_SWITCH |-> out_word.chose_idle || !out_word.switch_due)
    else $error("switch result carries tick fields");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the priority aging task scheduler.
// Depends on pats_pkg and priority_aging_task_scheduler.
`timescale 1ns / 1ps
module testbench;
  import pats_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      done;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  priority_aging_task_scheduler dut (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word), .busy(busy),
    .done(done), .out_word(out_word), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the scheduler state.
  logic [7:0]           sh_tslen;
  logic                 sh_valid [NUM_SLOTS];
  logic [1:0]           sh_state [NUM_SLOTS];
  logic [3:0]           sh_prio  [NUM_SLOTS];
  logic [ACC_WIDTH-1:0] sh_acc   [NUM_SLOTS];
  logic [15:0]          sh_sleep [NUM_SLOTS];
  logic [3:0]           sh_run;
  logic                 sh_run_idle;
  logic                 sh_first;
  logic [7:0]           sh_slice;

  in_word_t  pending_words[$];
  out_word_t sched_expect[$];
  int  errors = 0;
  int  n_ticks = 0, n_switch = 0, n_idle = 0, n_due = 0;
  bit  stim_done = 1'b0;

  // Gap lengths: mostly short, sometimes long, sometimes none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic out_word_t sched_step(in_word_t w);
    out_word_t r;
    logic [3:0] best;
    logic [ACC_WIDTH-1:0] max_acc;
    int max_pri;
    bit found;
    logic [ACC_WIDTH:0] sum;
    r = '0;
    case (w.action)
      ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (sh_valid[i] && sh_sleep[i] != 0) begin
            sh_sleep[i] = sh_sleep[i] - 16'd1;
            if (sh_sleep[i] == 0) sh_state[i] = ST_READY;
          end
        sh_slice = sh_slice - 8'd1;
        if (sh_slice != 0) r.timeslot_left = sh_slice;
        else begin
          sh_slice = sh_tslen;
          r.switch_due = 1'b1;
        end
      end
      ACT_SWITCH: begin
        sh_slice = sh_tslen;
        if (!sh_first && !w.current_killed && !sh_run_idle &&
            sh_valid[sh_run] && sh_state[sh_run] == ST_RUNNING)
          sh_state[sh_run] = ST_READY;
        sh_first = 1'b0;
        best = '0; max_acc = '0; max_pri = -1; found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!sh_valid[i] || sh_state[i] != ST_READY) continue;
          if (sh_acc[i] > max_acc ||
              (sh_acc[i] == max_acc && int'(sh_prio[i]) >= max_pri)) begin
            max_acc = sh_acc[i];
            max_pri = int'(sh_prio[i]);
            best = i[3:0];
            found = 1'b1;
          end
          sum = {1'b0, sh_acc[i]} + (ACC_WIDTH+1)'(sh_prio[i]) + (ACC_WIDTH+1)'(1);
          sh_acc[i] = sum[ACC_WIDTH] ? ACC_MAX : sum[ACC_WIDTH-1:0];
        end
        if (found) begin
          sh_acc[best] = '0;
          sh_state[best] = ST_RUNNING;
          sh_run = best;
          sh_run_idle = 1'b0;
          r.chosen_slot = best;
        end else begin
          sh_run = '0;
          sh_run_idle = 1'b1;
          r.chose_idle = 1'b1;
        end
      end
      ACT_WRITE: begin
        sh_valid[w.slot] = w.slot_valid;
        sh_state[w.slot] = w.slot_blocked ? ST_BLOCKED : ST_READY;
        sh_prio[w.slot]  = w.slot_priority;
        sh_sleep[w.slot] = w.slot_sleep;
        sh_acc[w.slot]   = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: one word at a time, random gap after each accepted word.
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sched_expect.push_back(sched_step(in_word));
        gap_left <= pick_gap();
        start <= 1'b0;
      end else if (!start) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: every done pulse is compared with the oldest prediction.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && done) begin
      if (sched_expect.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        errors++;
      end else begin
        e = sched_expect.pop_front();
        if (out_word.timeslot_left !== e.timeslot_left) begin
          $error("timeslot_left exp %0d got %0d", e.timeslot_left, out_word.timeslot_left);
          errors++;
        end
        if (out_word.switch_due !== e.switch_due) begin
          $error("switch_due exp %0d got %0d", e.switch_due, out_word.switch_due);
          errors++;
        end
        if (out_word.chosen_slot !== e.chosen_slot) begin
          $error("chosen_slot exp %0d got %0d", e.chosen_slot, out_word.chosen_slot);
          errors++;
        end
        if (out_word.chose_idle !== e.chose_idle) begin
          $error("chose_idle exp %0d got %0d", e.chose_idle, out_word.chose_idle);
          errors++;
        end
        if (e.switch_due) n_due++;
        if (e.chose_idle) n_idle++;
      end
    end
  end

  // Watchdog: cycles with no word accepted and no result seen.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || stim_done) stall_cycles <= 0;
    else if (stall_cycles == 5000) begin
      $display("FAILURE");
      $finish;
    end else stall_cycles <= stall_cycles + 1;
  end

  function automatic in_word_t mk_write(int s, bit v, bit b, int p, int slp);
    in_word_t w;
    w = '0;
    w.action = ACT_WRITE;
    w.slot = s[3:0];
    w.slot_valid = v;
    w.slot_blocked = b;
    w.slot_priority = p[3:0];
    w.slot_sleep = slp[15:0];
    return w;
  endfunction

  function automatic in_word_t mk_op(logic [1:0] a, bit k);
    in_word_t w;
    logic [31:0] rnd;
    rnd = $urandom();
    w = rnd[$bits(in_word_t)-1:0];  // noise in unused fields
    w.action = a;
    if (a == ACT_SWITCH) w.current_killed = k;
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || start || sched_expect.size() > 0)
      @(posedge clk);
    // the last result has been seen; wait a margin more before the next phase
    repeat (25) @(posedge clk);
  endtask

  task automatic set_tslen(logic [7:0] v);
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_tslen = v;
  endtask

  // Random phase: mix of writes, ticks and switches with random content.
  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        pending_words.push_back(mk_write($urandom_range(0, 15), $urandom_range(0, 99) < 85,
          $urandom_range(0, 2) == 0, $urandom_range(0, 15),
          ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 9) == 0) ?
          $urandom_range(0, 65535) : $urandom_range(1, 12))));
      else if (r < 65) begin
        pending_words.push_back(mk_op(ACT_TICK, 0));
        n_ticks++;
      end else if (r < 97) begin
        pending_words.push_back(mk_op(ACT_SWITCH, $urandom_range(0, 4) == 0));
        n_switch++;
      end else
        pending_words.push_back(mk_op(ACT_NOP, 0));
    end
    drain();
  endtask

  initial begin
    sh_tslen = TIMESLOT_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sh_valid[i] = 0; sh_state[i] = ST_READY; sh_prio[i] = 0;
      sh_acc[i] = 0; sh_sleep[i] = 0;
    end
    sh_run = 0; sh_run_idle = 1; sh_first = 1; sh_slice = TIMESLOT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Let the clearing pass run; the driver waits on busy anyway.
    @(posedge clk);

    // Directed: first switch with an empty table picks idle.
    pending_words.push_back(mk_op(ACT_SWITCH, 0));
    pending_words.push_back(mk_write(0, 1, 0, 0, 0));
    pending_words.push_back(mk_write(15, 1, 0, 15, 0));
    pending_words.push_back(mk_write(7, 1, 1, 15, 2));
    pending_words.push_back(mk_write(3, 1, 0, 15, 0));   // tie with slot 15
    pending_words.push_back(mk_write(9, 0, 0, 9, 65535)); // invalid slot
    pending_words.push_back(mk_write(4, 1, 1, 5, 65535));
    for (int i = 0; i < 6; i++) pending_words.push_back(mk_op(ACT_TICK, 0));
    pending_words.push_back(mk_op(ACT_SWITCH, 0));
    pending_words.push_back(mk_op(ACT_SWITCH, 0));
    pending_words.push_back(mk_op(ACT_SWITCH, 1));       // killed task
    pending_words.push_back(mk_op(ACT_NOP, 0));
    pending_words.push_back(mk_op(ACT_SWITCH, 0));
    pending_words.push_back(mk_write(15, 0, 1, 0, 0));
    pending_words.push_back(mk_op(ACT_SWITCH, 0));
    drain();

    // Extremes of the register, including zero which wraps the counter.
    set_tslen(8'd1);   random_phase(300);
    set_tslen(8'd255); random_phase(300);
    set_tslen(8'd0);   random_phase(250);
    set_tslen(8'd3);   random_phase(300);
    // Long run without writes after a full table, to push accumulators high.
    for (int i = 0; i < NUM_SLOTS; i++)
      pending_words.push_back(mk_write(i, 1, 0, 15, 0));
    for (int i = 0; i < 200; i++) pending_words.push_back(mk_op(ACT_SWITCH, 0));
    drain();
    set_tslen(8'($urandom_range(2, 254))); random_phase(450);
    stim_done = 1'b1;

    $display("Ran %0d random ticks and %0d random switches; %0d idle picks, %0d switch-due flags.",
             n_ticks, n_switch, n_idle, n_due);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
